// File: hw/rtl/http_request_byte_parser_macros.svh
// Assertion shorthands, clocked on i_clk and held off while i_rst_n is low.
`ifndef HTTP_REQUEST_BYTE_PARSER_MACROS_SVH
`define HTTP_REQUEST_BYTE_PARSER_MACROS_SVH

// Same-cycle implication.
`define HRBP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrbp assertion failed");

// Next-cycle implication.
`define HRBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrbp assertion failed");

`endif

// File: hw/rtl/hrbp_pkg.sv
package hrbp_pkg;

    localparam logic [3:0] KEY_LEN = 4'd14;

    // Parser states
    localparam logic [4:0] S_START        = 5'd0;
    localparam logic [4:0] S_METHOD       = 5'd1;
    localparam logic [4:0] S_BEFORE_PATH  = 5'd2;
    localparam logic [4:0] S_PATH         = 5'd3;
    localparam logic [4:0] S_BEFORE_PKEY  = 5'd4;
    localparam logic [4:0] S_PKEY         = 5'd5;
    localparam logic [4:0] S_BEFORE_PVAL  = 5'd6;
    localparam logic [4:0] S_PVAL         = 5'd7;
    localparam logic [4:0] S_BEFORE_PROTO = 5'd8;
    localparam logic [4:0] S_PROTO        = 5'd9;
    localparam logic [4:0] S_BEFORE_VER   = 5'd10;
    localparam logic [4:0] S_VER          = 5'd11;
    localparam logic [4:0] S_HKEY         = 5'd12;
    localparam logic [4:0] S_HVAL         = 5'd13;
    localparam logic [4:0] S_GOT_CR       = 5'd14;
    localparam logic [4:0] S_GOT_CRLF     = 5'd15;
    localparam logic [4:0] S_GOT_CRLFCR   = 5'd16;
    localparam logic [4:0] S_BODY         = 5'd17;
    localparam logic [4:0] S_COMPLETE     = 5'd18;
    localparam logic [4:0] S_INVALID      = 5'd19;

    // Token kinds
    localparam logic [3:0] K_NONE    = 4'd0;
    localparam logic [3:0] K_METHOD  = 4'd1;
    localparam logic [3:0] K_PATH    = 4'd2;
    localparam logic [3:0] K_PKEY    = 4'd3;
    localparam logic [3:0] K_PVAL    = 4'd4;
    localparam logic [3:0] K_PROTO   = 4'd5;
    localparam logic [3:0] K_VERSION = 4'd6;
    localparam logic [3:0] K_HKEY    = 4'd7;
    localparam logic [3:0] K_HVAL    = 4'd8;
    localparam logic [3:0] K_BODY    = 4'd9;

    // Status codes
    localparam logic [1:0] ST_PARSING  = 2'd0;
    localparam logic [1:0] ST_IN_BODY  = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // Opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_hrbp_in;

    typedef struct packed {
        logic [3:0] token_kind;
        logic       token_closed;
        logic [3:0] closed_kind;
        logic [1:0] parse_status;
        logic       byte_consumed;
    } t_hrbp_out;

    typedef struct packed {
        logic [4:0] parse_state;
        logic [3:0] key_match_index;
        logic       key_still_matching;
        logic       value_byte_skip;
        logic       digits_open;
        logic       length_present;
    } t_hrbp_ctl;

    typedef struct packed {
        logic clear_len;
        logic load_digit;
        logic clear_body;
        logic inc_body;
    } t_hrbp_len_cmd;

    typedef struct packed {
        logic len_zero;
        logic body_reached;
    } t_hrbp_len_flags;

    localparam t_hrbp_ctl CTL_RESET = '{
        parse_state:        S_START,
        key_match_index:    4'd0,
        key_still_matching: 1'b1,
        value_byte_skip:    1'b0,
        digits_open:        1'b0,
        length_present:     1'b0
    };

    // "Content-Length"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] status_of(input logic [4:0] st);
        logic [1:0] s;
        if (st == S_BODY) begin
            s = ST_IN_BODY;
        end else if (st == S_COMPLETE) begin
            s = ST_COMPLETE;
        end else if (st == S_INVALID) begin
            s = ST_INVALID;
        end else begin
            s = ST_PARSING;
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/hrbp_len.sv
// Content-Length digit accumulator and body counter datapath.
module hrbp_len
    import hrbp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic [7:0]             i_byte,
    input  logic [LENGTH_BITS-1:0] i_length,
    input  logic [LENGTH_BITS-1:0] i_body_count,
    output logic [LENGTH_BITS-1:0] o_length_acc,
    output logic [LENGTH_BITS-1:0] o_body_next,
    output t_hrbp_len_flags        o_flags
);

    localparam int AccW = LENGTH_BITS + 4;

    logic [AccW-1:0] len_wide;
    logic [AccW-1:0] acc_wide;

    // 10*L + d via shifts; any carry into the top nibble means saturation
    always_comb begin
        len_wide = {4'b0000, i_length};
        acc_wide = (len_wide << 3) + (len_wide << 1) + {{(AccW-4){1'b0}}, i_byte[3:0]};
        if (|acc_wide[AccW-1:LENGTH_BITS]) begin
            o_length_acc = '1;
        end else begin
            o_length_acc = acc_wide[LENGTH_BITS-1:0];
        end
    end

    assign o_body_next = (&i_body_count) ? i_body_count : i_body_count + 1'b1;

    assign o_flags.len_zero     = (i_length == '0);
    assign o_flags.body_reached = (o_body_next >= i_length);

endmodule

// File: hw/rtl/hrbp_step.sv
// One parser step: next control state, length commands and the result beat.
module hrbp_step
    import hrbp_pkg::*;
(
    input  t_hrbp_in        i_in,
    input  t_hrbp_ctl       i_ctl,
    input  t_hrbp_len_flags i_flags,
    output t_hrbp_ctl       o_ctl,
    output t_hrbp_len_cmd   o_cmd,
    output t_hrbp_out       o_out
);

    logic [7:0] b;
    logic [4:0] st;
    logic [4:0] ns;
    logic [3:0] kind;
    logic       closed;
    logic [3:0] ckind;
    logic       is_blank;
    logic       is_digit;
    logic       is_upper;
    logic       is_crlf;
    logic       key_hit;

    assign b        = i_in.data_byte;
    assign st       = i_ctl.parse_state;
    assign is_blank = (b == CH_SP) || (b == CH_TAB);
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_upper = (b >= 8'h41) && (b <= 8'h5A);
    assign is_crlf  = (b == CH_CR) || (b == CH_LF);
    assign key_hit  = i_ctl.key_still_matching && (i_ctl.key_match_index < KEY_LEN)
                      && (b == key_char(i_ctl.key_match_index));

    always_comb begin
        o_ctl  = i_ctl;
        o_cmd  = '0;
        ns     = st;
        kind   = K_NONE;
        closed = 1'b0;
        ckind  = K_NONE;
        o_out  = '0;

        if (i_in.opcode == OP_RESTART) begin
            o_ctl          = CTL_RESET;
            o_cmd.clear_len  = 1'b1;
            o_cmd.clear_body = 1'b1;
            o_out.parse_status = ST_PARSING;
        end else if (st == S_COMPLETE || st >= S_INVALID) begin
            // done: byte dropped, stray codes fold into invalid
            if (st > S_INVALID) begin
                o_ctl.parse_state = S_INVALID;
            end
            o_out.parse_status = status_of(o_ctl.parse_state);
        end else begin
            unique case (st)
                S_START: begin
                    if (is_crlf || is_blank) begin
                        ns = st;
                    end else if (is_upper) begin
                        ns = S_METHOD;
                        kind = K_METHOD;
                    end else begin
                        ns = S_INVALID;
                    end
                end
                S_METHOD: begin
                    if (is_upper) begin
                        kind = K_METHOD;
                    end else if (is_blank) begin
                        ns = S_BEFORE_PATH;
                        closed = 1'b1;
                        ckind = K_METHOD;
                    end else begin
                        ns = S_INVALID;
                    end
                end
                S_BEFORE_PATH: begin
                    if (b == CH_SLASH) begin
                        ns = S_PATH;
                        kind = K_PATH;
                    end else if (!is_blank) begin
                        ns = S_INVALID;
                    end
                end
                S_PATH: begin
                    if (b == CH_QUEST) begin
                        ns = S_BEFORE_PKEY;
                        closed = 1'b1;
                        ckind = K_PATH;
                    end else if (is_blank) begin
                        ns = S_BEFORE_PROTO;
                        closed = 1'b1;
                        ckind = K_PATH;
                    end else begin
                        kind = K_PATH;
                    end
                end
                S_BEFORE_PKEY: begin
                    if (is_blank || is_crlf) begin
                        ns = S_INVALID;
                    end else begin
                        ns = S_PKEY;
                        kind = K_PKEY;
                    end
                end
                S_PKEY: begin
                    if (b == CH_EQ) begin
                        ns = S_BEFORE_PVAL;
                        closed = 1'b1;
                        ckind = K_PKEY;
                    end else if (is_blank) begin
                        ns = S_INVALID;
                    end else begin
                        kind = K_PKEY;
                    end
                end
                S_BEFORE_PVAL: begin
                    if (is_blank || is_crlf) begin
                        ns = S_INVALID;
                    end else begin
                        ns = S_PVAL;
                        kind = K_PVAL;
                    end
                end
                S_PVAL: begin
                    if (b == CH_AMP) begin
                        ns = S_BEFORE_PKEY;
                        closed = 1'b1;
                        ckind = K_PVAL;
                    end else if (is_blank) begin
                        ns = S_BEFORE_PROTO;
                        closed = 1'b1;
                        ckind = K_PVAL;
                    end else begin
                        kind = K_PVAL;
                    end
                end
                S_BEFORE_PROTO: begin
                    if (!is_blank) begin
                        ns = S_PROTO;
                        kind = K_PROTO;
                    end
                end
                S_PROTO: begin
                    if (b == CH_SLASH) begin
                        ns = S_BEFORE_VER;
                        closed = 1'b1;
                        ckind = K_PROTO;
                    end else begin
                        kind = K_PROTO;
                    end
                end
                S_BEFORE_VER: begin
                    if (is_digit) begin
                        ns = S_VER;
                        kind = K_VERSION;
                    end else begin
                        ns = S_INVALID;
                    end
                end
                S_VER: begin
                    if (b == CH_CR) begin
                        ns = S_GOT_CR;
                        closed = 1'b1;
                        ckind = K_VERSION;
                    end else if (is_digit || b == CH_DOT) begin
                        kind = K_VERSION;
                    end else begin
                        ns = S_INVALID;
                    end
                end
                S_HKEY: begin
                    if (b == CH_COLON) begin
                        ns = S_HVAL;
                        closed = 1'b1;
                        ckind = K_HKEY;
                        o_ctl.value_byte_skip = 1'b1;
                        if (i_ctl.key_still_matching && i_ctl.key_match_index == KEY_LEN) begin
                            o_ctl.length_present = 1'b1;
                            o_ctl.digits_open    = 1'b1;
                            o_cmd.clear_len      = 1'b1;
                        end else begin
                            o_ctl.digits_open = 1'b0;
                        end
                    end else begin
                        kind = K_HKEY;
                        if (key_hit) begin
                            o_ctl.key_match_index = i_ctl.key_match_index + 4'd1;
                        end else begin
                            o_ctl.key_still_matching = 1'b0;
                        end
                    end
                end
                S_HVAL: begin
                    if (b == CH_CR) begin
                        ns = S_GOT_CR;
                        closed = 1'b1;
                        ckind = K_HVAL;
                        o_ctl.digits_open     = 1'b0;
                        o_ctl.value_byte_skip = 1'b0;
                    end else if (!(i_ctl.value_byte_skip && is_blank)) begin
                        o_ctl.value_byte_skip = 1'b0;
                        kind = K_HVAL;
                        if (i_ctl.digits_open) begin
                            if (is_digit) begin
                                o_cmd.load_digit = 1'b1;
                            end else begin
                                o_ctl.digits_open = 1'b0;
                            end
                        end
                    end
                end
                S_GOT_CR: begin
                    ns = (b == CH_LF) ? S_GOT_CRLF : S_INVALID;
                end
                S_GOT_CRLF: begin
                    if (b == CH_CR) begin
                        ns = S_GOT_CRLFCR;
                    end else if (is_blank) begin
                        ns = S_INVALID;
                    end else begin
                        // new header key, first byte checked against index zero
                        ns = S_HKEY;
                        kind = K_HKEY;
                        o_ctl.key_match_index    = (b == key_char(4'd0)) ? 4'd1 : 4'd0;
                        o_ctl.key_still_matching = (b == key_char(4'd0));
                    end
                end
                S_GOT_CRLFCR: begin
                    if (b == CH_LF) begin
                        if (i_ctl.length_present && i_flags.len_zero) begin
                            ns = S_COMPLETE;
                        end else begin
                            ns = S_BODY;
                        end
                    end else begin
                        ns = S_INVALID;
                    end
                end
                default: begin
                    kind = K_BODY;
                    o_cmd.inc_body = 1'b1;
                    if (i_ctl.length_present && i_flags.body_reached) begin
                        ns = S_COMPLETE;
                    end
                end
            endcase

            if (ns == S_INVALID) begin
                kind   = K_NONE;
                closed = 1'b0;
                ckind  = K_NONE;
            end
            o_ctl.parse_state   = ns;
            o_out.token_kind    = kind;
            o_out.token_closed  = closed;
            o_out.closed_kind   = ckind;
            o_out.parse_status  = status_of(ns);
            o_out.byte_consumed = 1'b1;
        end
    end

endmodule

// File: hw/rtl/http_request_byte_parser.sv
// HTTP/1.1 request byte parser. Each input beat carries one request byte or a
// restart command; each produces exactly one result beat with the byte's token
// kind, a token-closed flag, the parse status and a consumed flag. Each beat
// passes an input register, then a result register, and the block sustains one
// beat per cycle while i_out_ready is high: the parser state, Content-Length
// accumulator and body counter all update in the single cycle in which a beat
// moves from the input register into the result register.
// Content-Length is held in LENGTH_BITS bits and saturates at its maximum.
module http_request_byte_parser
    import hrbp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_hrbp_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_hrbp_out o_out_data
);

    logic                   r_s1_valid;
    t_hrbp_in               r_s1_data;
    logic                   r_out_valid;
    t_hrbp_out              r_out_data;
    t_hrbp_ctl              r_ctl;
    logic [LENGTH_BITS-1:0] r_length;
    logic [LENGTH_BITS-1:0] r_body_count;

    t_hrbp_ctl              n_ctl;
    t_hrbp_out              n_out_data;
    logic [LENGTH_BITS-1:0] n_length;
    logic [LENGTH_BITS-1:0] n_body_count;

    t_hrbp_len_cmd          len_cmd;
    t_hrbp_len_flags        len_flags;
    logic [LENGTH_BITS-1:0] length_acc;
    logic [LENGTH_BITS-1:0] body_next;
    logic                   advance;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    hrbp_len #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_len (
        .i_byte       (r_s1_data.data_byte),
        .i_length     (r_length),
        .i_body_count (r_body_count),
        .o_length_acc (length_acc),
        .o_body_next  (body_next),
        .o_flags      (len_flags)
    );

    hrbp_step u_step (
        .i_in    (r_s1_data),
        .i_ctl   (r_ctl),
        .i_flags (len_flags),
        .o_ctl   (n_ctl),
        .o_cmd   (len_cmd),
        .o_out   (n_out_data)
    );

    always_comb begin
        if (len_cmd.clear_len) begin
            n_length = '0;
        end else if (len_cmd.load_digit) begin
            n_length = length_acc;
        end else begin
            n_length = r_length;
        end
        if (len_cmd.clear_body) begin
            n_body_count = '0;
        end else if (len_cmd.inc_body) begin
            n_body_count = body_next;
        end else begin
            n_body_count = r_body_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ctl        <= CTL_RESET;
            r_length     <= '0;
            r_body_count <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_ctl        <= n_ctl;
                r_length     <= n_length;
                r_body_count <= n_body_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hw/rtl/hrbp_checker.sv
`include "http_request_byte_parser_macros.svh"

module hrbp_checker
    import hrbp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_hrbp_in  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_hrbp_out o_out_data
);

    logic out_stall;
    logic in_stall;
    logic untagged;
    logic no_token;
    logic body_beat;
    logic in_body_or_done;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_stall  = i_in_valid && !o_in_ready;
    assign untagged  = !o_out_data.byte_consumed || (o_out_data.parse_status == ST_INVALID);
    assign no_token  = (o_out_data.token_kind == K_NONE) && !o_out_data.token_closed
                       && (o_out_data.closed_kind == K_NONE);
    assign body_beat = o_out_valid && (o_out_data.token_kind == K_BODY);
    assign in_body_or_done = (o_out_data.parse_status == ST_IN_BODY)
                             || (o_out_data.parse_status == ST_COMPLETE);

    // a stalled result beat must hold
    `HRBP_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data))

    // a waiting input beat keeps its payload
    `HRBP_ASSERT_NEXT(a_in_hold, in_stall, i_in_valid && $stable(i_in_data))

    // dropped bytes and the byte that invalidates carry no token information
    `HRBP_ASSERT_IMPL(a_no_token, o_out_valid && untagged, no_token)

    // closed flag and closed kind agree
    `HRBP_ASSERT_IMPL(a_closed_kind, o_out_valid, o_out_data.token_closed == (o_out_data.closed_kind != K_NONE))

    // body bytes only while in body or at completion, and never close a token
    `HRBP_ASSERT_IMPL(a_body_status, body_beat, in_body_or_done && !o_out_data.token_closed)

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (.*);

// File: tb/sv/tb.sv
module tb;
    import hrbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LEN_BITS = 32;
    localparam logic [63:0] LEN_MAX  = 64'hFFFF_FFFF;
    localparam logic [111:0] CLEN_KEY = "Content-Length";

    localparam logic [7:0] DIG0 = 8'h30;
    localparam logic [7:0] DIG9 = 8'h39;
    localparam logic [7:0] UP_A = 8'h41;
    localparam logic [7:0] UP_Z = 8'h5A;

    localparam int GAP_PCT   [4] = '{0, 56, 0, 12};
    localparam int STALL_PCT [4] = '{0, 0, 56, 12};
    localparam int BEATS_PER_PHASE = 325;

    localparam t_hrbp_out RES_CLEAR = '0;
    localparam t_hrbp_out RES_BAD   = '{K_NONE, 1'b0, K_NONE, ST_INVALID, 1'b1};
    localparam t_hrbp_out RES_DROP  = '{K_NONE, 1'b0, K_NONE, ST_INVALID, 1'b0};

    typedef struct packed {
        t_hrbp_in  beat;
        logic      typed;
        t_hrbp_out want;
    } dir_row_t;

    // short walk through the request line into a body without Content-Length
    localparam dir_row_t DIR_TAB [27] = '{
        '{'{OP_RESTART, 8'hFF}, 1'b1, RES_CLEAR},
        '{'{OP_BYTE, 8'h00}, 1'b1, RES_BAD},
        '{'{OP_BYTE, 8'hFF}, 1'b1, RES_DROP},
        '{'{OP_RESTART, 8'h00}, 1'b1, RES_CLEAR},
        '{'{OP_BYTE, CH_LF}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, UP_Z}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_TAB}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_SLASH}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_QUEST}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, 8'h6B}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_EQ}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, 8'h76}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_AMP}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, 8'hFF}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_EQ}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, DIG0}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_SP}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, 8'h48}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_SLASH}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, DIG9}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_DOT}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_CR}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_LF}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_CR}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, CH_LF}, 1'b0, RES_CLEAR},
        '{'{OP_BYTE, 8'h00}, 1'b0, RES_CLEAR},
        '{'{OP_RESTART, 8'h5A}, 1'b1, RES_CLEAR}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_hrbp_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_hrbp_out o_out_data;

    http_request_byte_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser shadow state
    logic [4:0]  ps;
    logic [3:0]  key_pos;
    logic        key_live;
    logic        skip_lead;
    logic        num_open;
    logic        clen_seen;
    logic [63:0] clen_val;
    logic [63:0] body_seen;

    t_hrbp_out due_results [$];
    t_hrbp_out head;
    int        mismatches = 0;
    int        live_beats = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    bit        mangle = 1'b0;

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SP || b == CH_TAB;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= DIG0 && b <= DIG9;
    endfunction

    function automatic bit is_upper(logic [7:0] b);
        return b >= UP_A && b <= UP_Z;
    endfunction

    function automatic void parser_clear();
        ps        = S_START;
        key_pos   = '0;
        key_live  = 1'b1;
        skip_lead = 1'b0;
        num_open  = 1'b0;
        clen_seen = 1'b0;
        clen_val  = '0;
        body_seen = '0;
    endfunction

    function automatic void feed_key(logic [7:0] b);
        if (key_live && key_pos < KEY_LEN &&
            b == CLEN_KEY[8 * (13 - int'(key_pos)) +: 8]) begin
            key_pos = key_pos + 4'd1;
        end else begin
            key_live = 1'b0;
        end
    endfunction

    // next-state and tagging of one beat; updates the shadow state
    function automatic t_hrbp_out tag_byte(t_hrbp_in beat);
        t_hrbp_out   r;
        logic [7:0]  b;
        logic [4:0]  nxt;
        logic [3:0]  shut;
        logic [63:0] d;
        r = '0;
        b = beat.data_byte;
        nxt = ps;
        shut = K_NONE;
        if (beat.opcode == OP_RESTART) begin
            parser_clear();
            return r;
        end
        if (ps == S_COMPLETE || ps == S_INVALID) begin
            r.parse_status = (ps == S_COMPLETE) ? ST_COMPLETE : ST_INVALID;
            return r;
        end
        r.byte_consumed = 1'b1;
        case (ps)
            S_START: begin
                if (is_upper(b)) begin
                    nxt = S_METHOD;
                    r.token_kind = K_METHOD;
                end else if (!(b == CH_CR || b == CH_LF || is_blank(b))) begin
                    nxt = S_INVALID;
                end
            end
            S_METHOD: begin
                if (is_upper(b)) begin
                    r.token_kind = K_METHOD;
                end else if (is_blank(b)) begin
                    nxt = S_BEFORE_PATH;
                    shut = K_METHOD;
                end else begin
                    nxt = S_INVALID;
                end
            end
            S_BEFORE_PATH: begin
                if (b == CH_SLASH) begin
                    nxt = S_PATH;
                    r.token_kind = K_PATH;
                end else if (!is_blank(b)) begin
                    nxt = S_INVALID;
                end
            end
            S_PATH: begin
                if (b == CH_QUEST) begin
                    nxt = S_BEFORE_PKEY;
                    shut = K_PATH;
                end else if (is_blank(b)) begin
                    nxt = S_BEFORE_PROTO;
                    shut = K_PATH;
                end else begin
                    r.token_kind = K_PATH;
                end
            end
            S_BEFORE_PKEY, S_BEFORE_PVAL: begin
                if (is_blank(b) || b == CH_CR || b == CH_LF) begin
                    nxt = S_INVALID;
                end else if (ps == S_BEFORE_PKEY) begin
                    nxt = S_PKEY;
                    r.token_kind = K_PKEY;
                end else begin
                    nxt = S_PVAL;
                    r.token_kind = K_PVAL;
                end
            end
            S_PKEY: begin
                if (b == CH_EQ) begin
                    nxt = S_BEFORE_PVAL;
                    shut = K_PKEY;
                end else if (is_blank(b)) begin
                    nxt = S_INVALID;
                end else begin
                    r.token_kind = K_PKEY;
                end
            end
            S_PVAL: begin
                if (b == CH_AMP) begin
                    nxt = S_BEFORE_PKEY;
                    shut = K_PVAL;
                end else if (is_blank(b)) begin
                    nxt = S_BEFORE_PROTO;
                    shut = K_PVAL;
                end else begin
                    r.token_kind = K_PVAL;
                end
            end
            S_BEFORE_PROTO: begin
                if (!is_blank(b)) begin
                    nxt = S_PROTO;
                    r.token_kind = K_PROTO;
                end
            end
            S_PROTO: begin
                if (b == CH_SLASH) begin
                    nxt = S_BEFORE_VER;
                    shut = K_PROTO;
                end else begin
                    r.token_kind = K_PROTO;
                end
            end
            S_BEFORE_VER: begin
                if (is_digit(b)) begin
                    nxt = S_VER;
                    r.token_kind = K_VERSION;
                end else begin
                    nxt = S_INVALID;
                end
            end
            S_VER: begin
                if (b == CH_CR) begin
                    nxt = S_GOT_CR;
                    shut = K_VERSION;
                end else if (is_digit(b) || b == CH_DOT) begin
                    r.token_kind = K_VERSION;
                end else begin
                    nxt = S_INVALID;
                end
            end
            S_HKEY: begin
                if (b == CH_COLON) begin
                    nxt = S_HVAL;
                    shut = K_HKEY;
                    skip_lead = 1'b1;
                    num_open = key_live && key_pos == KEY_LEN;
                    if (num_open) begin
                        clen_seen = 1'b1;
                        clen_val = '0;
                    end
                end else begin
                    r.token_kind = K_HKEY;
                    feed_key(b);
                end
            end
            S_HVAL: begin
                if (b == CH_CR) begin
                    nxt = S_GOT_CR;
                    shut = K_HVAL;
                    num_open = 1'b0;
                    skip_lead = 1'b0;
                end else if (!(skip_lead && is_blank(b))) begin
                    skip_lead = 1'b0;
                    r.token_kind = K_HVAL;
                    if (num_open && is_digit(b)) begin
                        d = 64'(b - DIG0);
                        if (clen_val > (LEN_MAX - d) / 10) begin
                            clen_val = LEN_MAX;
                        end else begin
                            clen_val = clen_val * 10 + d;
                        end
                    end else begin
                        num_open = 1'b0;
                    end
                end
            end
            S_GOT_CR: begin
                nxt = (b == CH_LF) ? S_GOT_CRLF : S_INVALID;
            end
            S_GOT_CRLF: begin
                if (b == CH_CR) begin
                    nxt = S_GOT_CRLFCR;
                end else if (is_blank(b)) begin
                    nxt = S_INVALID;
                end else begin
                    nxt = S_HKEY;
                    r.token_kind = K_HKEY;
                    key_pos = '0;
                    key_live = 1'b1;
                    feed_key(b);
                end
            end
            S_GOT_CRLFCR: begin
                if (b != CH_LF) begin
                    nxt = S_INVALID;
                end else if (clen_seen && clen_val == 0) begin
                    nxt = S_COMPLETE;
                end else begin
                    nxt = S_BODY;
                end
            end
            default: begin
                r.token_kind = K_BODY;
                if (body_seen < LEN_MAX) begin
                    body_seen = body_seen + 1;
                end
                if (clen_seen && body_seen >= clen_val) begin
                    nxt = S_COMPLETE;
                end
            end
        endcase
        if (nxt == S_INVALID) begin
            r.token_kind = K_NONE;
            shut = K_NONE;
        end
        r.token_closed = (shut != K_NONE);
        r.closed_kind = shut;
        case (nxt)
            S_BODY:     r.parse_status = ST_IN_BODY;
            S_COMPLETE: r.parse_status = ST_COMPLETE;
            S_INVALID:  r.parse_status = ST_INVALID;
            default:    r.parse_status = ST_PARSING;
        endcase
        ps = nxt;
        return r;
    endfunction

    task automatic send_beat(t_hrbp_in beat, logic typed, t_hrbp_out want);
        t_hrbp_out guess;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        guess = tag_byte(beat);
        due_results.push_back(typed ? want : guess);
        if (guess.byte_consumed || beat.opcode == OP_RESTART) begin
            live_beats++;
        end
    endtask

    task automatic emit(logic [7:0] c);
        t_hrbp_in beat;
        beat.opcode = OP_BYTE;
        beat.data_byte = (mangle && $urandom_range(0, 39) == 0) ? 8'($urandom) : c;
        send_beat(beat, 1'b0, RES_CLEAR);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
        end
    endtask

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? CH_SP : CH_TAB;
    endfunction

    function automatic logic [7:0] rand_digit();
        return DIG0 + 8'($urandom_range(0, 9));
    endfunction

    // any byte except blanks, CR, LF and the given delimiter
    function automatic logic [7:0] rand_field_byte(logic [7:0] stop);
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (is_blank(c) || c == CH_CR || c == CH_LF || c == stop);
        return c;
    endfunction

    function automatic logic [7:0] rand_key_char();
        case ($urandom_range(0, 3))
            0:       return 8'h2D;
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            default: return UP_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic emit_length_value();
        repeat ($urandom_range(0, 2)) emit(rand_blank());
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                repeat ($urandom_range(0, 2)) emit(DIG0);
                emit(rand_digit());
            end
            3: begin
                emit(DIG0 + 8'($urandom_range(1, 9)));
                emit(rand_digit());
            end
            4: put_str("4294967295");
            5: begin
                if ($urandom_range(0, 1)) begin
                    put_str("4294967296");
                end else begin
                    emit(DIG0 + 8'($urandom_range(5, 9)));
                    repeat ($urandom_range(9, 19)) emit(rand_digit());
                end
            end
            6: begin
                emit($urandom_range(0, 1) ? 8'h2D : 8'h2B);
                emit(rand_digit());
            end
            default: ;
        endcase
        // junk after the digits freezes the value
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) emit(rand_blank());
            repeat ($urandom_range(1, 3)) emit(rand_field_byte(CH_CR));
        end
    endtask

    task automatic random_request();
        t_hrbp_in beat;
        int       pick;
        beat.opcode = OP_RESTART;
        beat.data_byte = 8'($urandom);
        if ($urandom_range(0, 9) != 0) send_beat(beat, 1'b0, RES_CLEAR);
        pick = $urandom_range(0, 99);
        mangle = (pick < 20);
        if (pick >= 90) begin
            repeat ($urandom_range(5, 20)) emit(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0:       emit(CH_CR);
                1:       emit(CH_LF);
                default: emit(rand_blank());
            endcase
        end
        repeat ($urandom_range(1, 6)) emit(UP_A + 8'($urandom_range(0, 25)));
        repeat ($urandom_range(1, 2)) emit(rand_blank());
        emit(CH_SLASH);
        repeat ($urandom_range(0, 6)) emit(rand_field_byte(CH_QUEST));
        if ($urandom_range(0, 1)) begin
            emit(CH_QUEST);
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
                repeat ($urandom_range(1, 4)) emit(rand_field_byte(CH_EQ));
                emit(CH_EQ);
                repeat ($urandom_range(1, 4)) emit(rand_field_byte(CH_AMP));
                if (i > 1) emit(CH_AMP);
            end
        end
        repeat ($urandom_range(1, 2)) emit(rand_blank());
        if ($urandom_range(0, 3) != 0) begin
            put_str("HTTP");
        end else begin
            repeat ($urandom_range(1, 4)) emit(rand_field_byte(CH_SLASH));
        end
        emit(CH_SLASH);
        emit(rand_digit());
        repeat ($urandom_range(0, 3)) emit($urandom_range(0, 1) ? CH_DOT : rand_digit());
        emit(CH_CR);
        emit(CH_LF);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_str("Content-Length");
                4:          put_str("Content-Lengt");
                5:          put_str("Content-Lengthh");
                6:          put_str("content-length");
                default: begin
                    repeat ($urandom_range(1, 8)) emit(rand_key_char());
                end
            endcase
            emit(CH_COLON);
            if (ps == S_HVAL && num_open) begin
                emit_length_value();
            end else begin
                repeat ($urandom_range(0, 2)) emit(rand_blank());
                repeat ($urandom_range(0, 8)) emit(rand_field_byte(CH_CR));
            end
            emit(CH_CR);
            emit(CH_LF);
        end
        emit(CH_CR);
        emit(CH_LF);
        repeat ($urandom_range(0, 12)) emit(8'($urandom));
    endtask

    task automatic check_field(string fname, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result beat with none expected, got %p", $time, o_out_data);
                mismatches++;
            end else begin
                head = due_results.pop_front();
                check_field("token_kind", head.token_kind, o_out_data.token_kind);
                check_field("token_closed", 4'(head.token_closed),
                            4'(o_out_data.token_closed));
                check_field("closed_kind", head.closed_kind, o_out_data.closed_kind);
                check_field("parse_status", 4'(head.parse_status),
                            4'(o_out_data.parse_status));
                check_field("byte_consumed", 4'(head.byte_consumed),
                            4'(o_out_data.byte_consumed));
            end
        end
    end

    initial begin
        #3_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        int phase_end;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        parser_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 27; i++) begin
            send_beat(DIR_TAB[i].beat, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = GAP_PCT[ph];
            recv_stall_pct = STALL_PCT[ph];
            phase_end = live_beats + BEATS_PER_PHASE;
            while (live_beats < phase_end) begin
                random_request();
            end
            // hold the sender off until every result of this phase is back
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            while (due_results.size() != 0) @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
